@@ hw/rtl/mtfzr_pkg.sv @@
// Package for the move-to-front zero-run tokenizer.
// Shared types, token codes and controller/datapath command and status structs.
package mtfzr_pkg;

    localparam int RUN_WIDTH = 20;
    localparam int RUN_CNT_W = $clog2(RUN_WIDTH + 1);

    localparam logic [3:0] CTX_BUCKET = 4'd0;
    localparam logic [3:0] CTX_RAW    = 4'd8;
    localparam logic [7:0] TOK_RUN_A  = 8'd0;
    localparam logic [7:0] TOK_RUN_B  = 8'd1;
    localparam logic [7:0] TOK_EOB    = 8'd2;
    localparam logic [7:0] TOK_ONE    = 8'd3;

    localparam logic [1:0] TSEL_RAW    = 2'd0;
    localparam logic [1:0] TSEL_DIGIT  = 2'd1;
    localparam logic [1:0] TSEL_BUCKET = 2'd2;
    localparam logic [1:0] TSEL_OFFSET = 2'd3;

    typedef struct packed {
        logic       load;
        logic       scan;
        logic       shift_run;
        logic       bump_run;
        logic       clear_run;
        logic       emit;
        logic [1:0] tsel;
        logic [1:0] byte_idx;
        logic       eob;
        logic       last;
    } mtfzr_cmd_t;

    typedef struct packed {
        logic                 command;
        logic                 block_end;
        logic [7:0]           pos;
        logic                 run_nonzero;
        logic                 run_digits_left;
        logic                 out_busy;
    } mtfzr_stat_t;

endpackage

@@ hw/rtl/mtfzr_datapath.sv @@
// Datapath: MTF list registers, parallel lookup and shift, run counter, token output register.
// Depends on mtfzr_pkg.
module mtfzr_datapath
    import mtfzr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  mtfzr_cmd_t  cmd,
    output mtfzr_stat_t stat,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic [3:0]  m_tuser,
    output logic        m_tlast
);

    logic [7:0]           list_reg [256];
    logic [7:0]           byte_reg;
    logic [31:0]          word_reg;
    logic                 cmd_reg, end_reg;
    logic [7:0]           pos_reg;
    logic [RUN_WIDTH-1:0] run_reg;
    logic [RUN_WIDTH-1:0] digits_reg;
    logic [RUN_CNT_W-1:0] ndig_reg;
    logic [3:0]           ctx_reg;
    logic [7:0]           val_reg;
    logic                 last_reg;

    logic [255:0] hit;
    logic [7:0]   pos_next;
    logic [2:0]   bk;
    logic [3:0]   ctx_next;
    logic [7:0]   val_next;
    logic [RUN_WIDTH:0] rp1;

    always_comb
    begin
        pos_next = 8'd255;
        for (int i = 255; i >= 0; i--)
        begin
            hit[i] = (list_reg[i] == byte_reg);
            if (hit[i])
                pos_next = 8'(i);
        end
    end

    always_comb
    begin
        bk = 3'd1;
        for (int b = 7; b >= 2; b--)
            if (pos_reg[b] && bk == 3'd1)
                bk = 3'(b);
    end

    // bijective base-2 digits of run: digits of (run+1) without the leading one
    always_comb
    begin
        rp1 = {1'b0, run_reg} + 1'b1;
    end

    always_comb
    begin
        ctx_next = CTX_BUCKET;
        val_next = TOK_EOB;
        unique case (cmd.tsel)
            TSEL_RAW:
            begin
                ctx_next = CTX_RAW;
                val_next = word_reg[8*(3-cmd.byte_idx) +: 8];
            end
            TSEL_DIGIT:
            begin
                val_next = digits_reg[ndig_reg - 1'b1] ? TOK_RUN_B : TOK_RUN_A;
            end
            TSEL_BUCKET:
            begin
                if (cmd.eob)
                    val_next = TOK_EOB;
                else if (pos_reg == 8'd1)
                    val_next = TOK_ONE;
                else
                    val_next = TOK_ONE + 8'(bk);
            end
            TSEL_OFFSET:
            begin
                ctx_next = {1'b0, bk};
                val_next = pos_reg & ~(8'd1 << bk);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 256; i++)
                list_reg[i] <= 8'(i);
            run_reg    <= '0;
            digits_reg <= '0;
            ndig_reg   <= '0;
            m_tvalid   <= 1'b0;
        end
        else
        begin
            if (cmd.scan)
            begin
                for (int i = 1; i < 256; i++)
                    if (8'(i) <= pos_next)
                        list_reg[i] <= list_reg[i-1];
                list_reg[0] <= byte_reg;
            end
            if (cmd.bump_run && run_reg != {RUN_WIDTH{1'b1}})
                run_reg <= run_reg + 1'b1;
            if (cmd.shift_run)
            begin
                // load digit register: run+1 bits below the top one
                digits_reg <= rp1[RUN_WIDTH-1:0];
                ndig_reg   <= '0;
                for (int b = 1; b <= RUN_WIDTH; b++)
                    if (rp1[b])
                        ndig_reg <= RUN_CNT_W'(b);
            end
            if (cmd.emit && cmd.tsel == TSEL_DIGIT)
                ndig_reg <= ndig_reg - 1'b1;
            if (cmd.clear_run)
                run_reg <= '0;
            if (cmd.emit)
                m_tvalid <= 1'b1;
            else if (m_tready)
                m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg  <= s_tuser;
            byte_reg <= s_tdata[7:0];
            end_reg  <= s_tlast;
            word_reg <= s_tdata[39:8];
        end
        if (cmd.scan)
            pos_reg <= pos_next;
        if (cmd.emit)
        begin
            ctx_reg  <= ctx_next;
            val_reg  <= val_next;
            last_reg <= cmd.last;
        end
    end

    assign m_tdata = val_reg;
    assign m_tuser = ctx_reg;
    assign m_tlast = last_reg;

    assign stat.command         = cmd_reg;
    assign stat.block_end       = end_reg;
    assign stat.pos             = pos_reg;
    assign stat.run_nonzero     = (run_reg != '0);
    assign stat.run_digits_left = (ndig_reg != '0);
    assign stat.out_busy        = m_tvalid && !m_tready;

endmodule

@@ hw/rtl/mtfzr_ctrl.sv @@
// Controller: sequences lookup, run flush, position, end-of-block and raw word tokens.
// Depends on mtfzr_pkg.
module mtfzr_ctrl
    import mtfzr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  mtfzr_stat_t stat,
    output mtfzr_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_DIGIT  = 3'd3;
    localparam logic [2:0] ST_BUCKET = 3'd4;
    localparam logic [2:0] ST_OFFSET = 3'd5;
    localparam logic [2:0] ST_EOB    = 3'd6;
    localparam logic [2:0] ST_RAW    = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic       phase_reg, phase_next;   // 0 flush before position, 1 before eob

    logic pos_nz, need_off, go;
    assign pos_nz   = stat.pos != 8'd0;
    assign need_off = stat.pos > 8'd1;
    assign go       = !stat.out_busy;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.command)
                begin
                    idx_next   = 2'd0;
                    state_next = ST_RAW;
                end
                else
                begin
                    cmd.scan   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (pos_nz)
                begin
                    cmd.shift_run = 1'b1;
                    cmd.clear_run = 1'b1;
                    phase_next    = 1'b0;
                    state_next    = stat.run_nonzero ? ST_DIGIT : ST_BUCKET;
                end
                else
                begin
                    cmd.bump_run = 1'b1;
                    phase_next   = 1'b1;
                    state_next   = stat.block_end ? ST_EOB : ST_IDLE;
                end
                if (!pos_nz && stat.block_end)
                begin
                    // flush happens from ST_EOB after bump takes effect
                    state_next = ST_EOB;
                    idx_next   = 2'd1;
                end
            end
            ST_DIGIT:
            begin
                cmd.tsel = TSEL_DIGIT;
                if (!stat.run_digits_left)
                    state_next = phase_reg ? ST_EOB : ST_BUCKET;
                else if (go)
                begin
                    cmd.emit = 1'b1;
                end
            end
            ST_BUCKET:
            begin
                cmd.tsel = TSEL_BUCKET;
                if (go)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = !need_off && !stat.block_end;
                    if (need_off)
                        state_next = ST_OFFSET;
                    else if (stat.block_end)
                    begin
                        state_next = ST_EOB;
                        idx_next   = 2'd0;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_OFFSET:
            begin
                cmd.tsel = TSEL_OFFSET;
                if (go)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = !stat.block_end;
                    idx_next   = 2'd0;
                    state_next = stat.block_end ? ST_EOB : ST_IDLE;
                end
            end
            ST_EOB:
            begin
                cmd.tsel = TSEL_BUCKET;
                cmd.eob  = 1'b1;
                if (idx_reg == 2'd1)
                begin
                    // run may still be pending: load digits first
                    idx_next = 2'd0;
                    if (stat.run_nonzero)
                    begin
                        cmd.shift_run = 1'b1;
                        cmd.clear_run = 1'b1;
                        phase_next    = 1'b1;
                        state_next    = ST_DIGIT;
                    end
                end
                else if (go)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RAW:
            begin
                cmd.tsel     = TSEL_RAW;
                cmd.byte_idx = idx_reg;
                if (go)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = idx_reg == 2'd3;
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= 2'd0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
        end
    end

endmodule

@@ hw/rtl/mtf_zero_run_tokenizer.sv @@
// Top level of the move-to-front zero-run tokenizer.
// Depends on mtfzr_pkg, mtfzr_ctrl, mtfzr_datapath.
//
//  channel  | direction | payload
//  s_axis   | in        | tuser command, tdata data_byte/word_value, tlast block_end
//  m_axis   | out       | tuser token_context, tdata token_value, tlast token_last
//
// A data transaction is accepted, looked up and decided, then emits its tokens;
// a run flush leaves ST_DIGIT once its digits are out, and a zero position that
// ends a block first visits ST_EOB to flush the run. A word emits four tokens.
// The MTF list is looked up and shifted in the same cycle. Reset restores the
// identity list and a zero run count at once. Output stalls hold the controller;
// a new transaction waits for idle.
module mtf_zero_run_tokenizer
    import mtfzr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_byte, word_value
    input  logic        s_axis_tuser,   // command
    input  logic        s_axis_tlast,   // block_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // token_value
    output logic [3:0]  m_axis_tuser,   // token_context
    output logic        m_axis_tlast    // token_last
);

    mtfzr_cmd_t  cmd;
    mtfzr_stat_t stat;

    mtfzr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mtfzr_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .s_tlast  (s_axis_tlast),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .m_tlast  (m_axis_tlast)
    );

    a_no_emit_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        stat.out_busy |-> !cmd.emit) else $error("token overwritten");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !s_axis_tready) else $error("accept during emit");

endmodule
